### src/sicc_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the snoop invalidate coherence controller.
// Holds field widths, config indexes, mode, line state, event, request and action codes, and the command struct.
package sicc_pkg;

    localparam int LINE_COUNT_DEFAULT = 256;

    localparam int INDEX_W    = 8;
    localparam int INDEX_SPAN = 256;
    localparam int ADDR_W     = 64;
    localparam int STATE_W    = 4;
    localparam int EVENT_W    = 3;
    localparam int KIND_W     = 2;
    localparam int ACT_W      = 2;
    localparam int MODE_W     = 2;
    localparam int CACHE_W    = 4;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_ID      = 1'd1;

    // Protocol rule sets.
    localparam logic [MODE_W-1:0] MODE_MI    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MSI   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MESI  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MOESI = 2'd3;

    // Line coherence states, stable and transient.
    localparam logic [STATE_W-1:0] ST_I  = 4'd0;
    localparam logic [STATE_W-1:0] ST_M  = 4'd1;
    localparam logic [STATE_W-1:0] ST_S  = 4'd2;
    localparam logic [STATE_W-1:0] ST_E  = 4'd3;
    localparam logic [STATE_W-1:0] ST_O  = 4'd4;
    localparam logic [STATE_W-1:0] ST_IM = 4'd5;
    localparam logic [STATE_W-1:0] ST_IS = 4'd6;
    localparam logic [STATE_W-1:0] ST_SM = 4'd7;
    localparam logic [STATE_W-1:0] ST_OM = 4'd8;

    // Snooped bus events.
    localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
    localparam logic [EVENT_W-1:0] EV_RD     = 3'd1;
    localparam logic [EVENT_W-1:0] EV_WR     = 3'd2;
    localparam logic [EVENT_W-1:0] EV_DATA   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_SHARED = 3'd4;

    // Issued bus request kinds.
    localparam logic [KIND_W-1:0] KIND_RD     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WR     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SHARED = 2'd3;

    // Snoop cache actions.
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INV   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SHARE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RECV  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the incoming transaction and read its line state
        logic execute;  // apply the transition, write back, load the result register
    } cmd_t;

endpackage

### src/snoop_invalidate_coherence_controller_core.sv
`timescale 1ns / 1ps
// Snooping invalidation coherence controller, top level.
// Instantiates sicc_ctrl and sicc_datapath; depends on sicc_pkg.
//
// Usage:
// The s_ channel carries one transaction per item: a processor access or a
// snooped bus event together with a line index and a full address. The m_
// channel returns exactly one result transaction per input transaction, in
// order: the new line state, permission, snoop action, an optional bus
// request with address and cache id, an error flag and the request count.
// The cfg channel writes the protocol mode (index 0) and the cache id
// (index 1); it is always ready and should be used only while idle.
// Each transaction takes two steps: capture reads the line state memory and
// execute applies the transition and writes it back. With the memory's single
// read-modify-write port, a new transaction is accepted only after the last
// one has executed, and execute loads the result into the output register.
// A result waiting in the output register does not block the next input
// transaction; a stalled receiver holds m_valid and its payload, and the
// block stops taking input once a second result is ready to be loaded.
// Reset clears all line valid bits at once, so every line reads as invalid,
// sets MOESI mode, cache id zero and a zero request count.
module snoop_invalidate_coherence_controller_core #(
    parameter int LINE_COUNT = sicc_pkg::LINE_COUNT_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sicc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sicc_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_opcode,
    input  logic                                s_is_read,
    input  logic [sicc_pkg::EVENT_W-1:0]        s_bus_event,
    input  logic [sicc_pkg::INDEX_W-1:0]        s_line_index,
    input  logic [sicc_pkg::ADDR_W-1:0]         s_address,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sicc_pkg::STATE_W-1:0]        m_next_state,
    output logic                                m_perm_avail,
    output logic [sicc_pkg::ACT_W-1:0]          m_snoop_action,
    output logic                                m_bus_send,
    output logic [sicc_pkg::KIND_W-1:0]         m_bus_kind,
    output logic [sicc_pkg::ADDR_W-1:0]         m_bus_address,
    output logic [sicc_pkg::CACHE_W-1:0]        m_bus_cache,
    output logic                                m_protocol_error,
    output logic [sicc_pkg::COUNT_W-1:0]        m_requests_sent
);
    import sicc_pkg::*;

    cmd_t cmd;
    logic cfg_we;

    // Register writes complete in the cycle they are presented.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // The controller sequences each transaction and owns both valid/ready pairs.
    sicc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // The datapath holds the line states, the transition rules and the result.
    sicc_datapath #(
        .LINE_COUNT (LINE_COUNT)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_opcode         (s_opcode),
        .s_is_read        (s_is_read),
        .s_bus_event      (s_bus_event),
        .s_line_index     (s_line_index),
        .s_address        (s_address),
        .m_next_state     (m_next_state),
        .m_perm_avail     (m_perm_avail),
        .m_snoop_action   (m_snoop_action),
        .m_bus_send       (m_bus_send),
        .m_bus_kind       (m_bus_kind),
        .m_bus_address    (m_bus_address),
        .m_bus_cache      (m_bus_cache),
        .m_protocol_error (m_protocol_error),
        .m_requests_sent  (m_requests_sent)
    );

endmodule

### src/sicc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences lookup and execute, owns the handshakes.
// Depends on sicc_pkg.
module sicc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output sicc_pkg::cmd_t cmd
);
    import sicc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } fsm_state_t;

    fsm_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd.capture    = 1'b0;
        cmd.execute    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    cmd.execute    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/sicc_datapath.sv
`timescale 1ns / 1ps
// Datapath: line state memory with valid bits, transition rules, request counter,
// configuration registers and the result register. Depends on sicc_pkg.
module sicc_datapath #(
    parameter int LINE_COUNT = sicc_pkg::LINE_COUNT_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sicc_pkg::cmd_t                      cmd,
    input  logic                                cfg_we,
    input  logic [sicc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sicc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_opcode,
    input  logic                                s_is_read,
    input  logic [sicc_pkg::EVENT_W-1:0]        s_bus_event,
    input  logic [sicc_pkg::INDEX_W-1:0]        s_line_index,
    input  logic [sicc_pkg::ADDR_W-1:0]         s_address,
    output logic [sicc_pkg::STATE_W-1:0]        m_next_state,
    output logic                                m_perm_avail,
    output logic [sicc_pkg::ACT_W-1:0]          m_snoop_action,
    output logic                                m_bus_send,
    output logic [sicc_pkg::KIND_W-1:0]         m_bus_kind,
    output logic [sicc_pkg::ADDR_W-1:0]         m_bus_address,
    output logic [sicc_pkg::CACHE_W-1:0]        m_bus_cache,
    output logic                                m_protocol_error,
    output logic [sicc_pkg::COUNT_W-1:0]        m_requests_sent
);
    import sicc_pkg::*;

    // Only lines reachable through an 8-bit index need storage.
    localparam int DEPTH = (LINE_COUNT < INDEX_SPAN) ? LINE_COUNT : INDEX_SPAN;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic [STATE_W-1:0] nxt;
        logic               perm;
        logic [ACT_W-1:0]   act;
        logic               err;
        logic               send;
        logic [KIND_W-1:0]  kind;
    } decision_t;

    function automatic decision_t decide(
        input logic [MODE_W-1:0]  mode,
        input logic [STATE_W-1:0] cur,
        input logic               snoop,
        input logic               rd,
        input logic [EVENT_W-1:0] ev
    );
        decision_t d;
        logic      rdlike;
        logic      ok;
        d.nxt  = cur;
        d.perm = 1'b0;
        d.act  = ACT_NONE;
        d.err  = 1'b0;
        d.send = 1'b0;
        d.kind = KIND_RD;
        rdlike = (ev == EV_SHARED) || (ev == EV_RD);
        case (cur)
            ST_I, ST_M, ST_IM:   ok = 1'b1;
            ST_S, ST_IS, ST_SM:  ok = (mode != MODE_MI);
            ST_E:                ok = (mode == MODE_MESI) || (mode == MODE_MOESI);
            ST_O, ST_OM:         ok = (mode == MODE_MOESI);
            default:             ok = 1'b0;
        endcase

        if (!ok) begin
            d.nxt = ST_I;
            d.err = 1'b1;
        end else if (!snoop) begin
            case (cur)
                ST_I: begin
                    d.send = 1'b1;
                    if (rd && (mode != MODE_MI)) begin
                        d.kind = KIND_RD;
                        d.nxt  = ST_IS;
                    end else begin
                        d.kind = KIND_WR;
                        d.nxt  = ST_IM;
                    end
                end
                ST_M: begin
                    d.perm = 1'b1;
                end
                ST_S, ST_O: begin
                    if (rd) begin
                        d.perm = 1'b1;
                    end else begin
                        d.send = 1'b1;
                        d.kind = KIND_WR;
                        d.nxt  = (cur == ST_S) ? ST_SM : ST_OM;
                    end
                end
                ST_E: begin
                    d.perm = 1'b1;
                    if (!rd) begin
                        d.nxt = ST_M;
                    end
                end
                default: begin
                    // Processor access while a bus transaction is outstanding.
                    d.err = 1'b1;
                end
            endcase
        end else begin
            case (cur)
                ST_M: begin
                    if (mode == MODE_MI) begin
                        d.send = 1'b1;
                        d.kind = KIND_DATA;
                        d.act  = ACT_INV;
                        d.nxt  = ST_I;
                    end else if (mode == MODE_MSI) begin
                        d.send = 1'b1;
                        d.kind = KIND_DATA;
                        if (rdlike) begin
                            d.act = ACT_SHARE;
                            d.nxt = ST_S;
                        end else if (ev == EV_WR) begin
                            d.act = ACT_INV;
                            d.nxt = ST_I;
                        end
                    end else if (rdlike) begin
                        d.send = 1'b1;
                        d.kind = KIND_SHARED;
                        d.act  = ACT_SHARE;
                        d.nxt  = (mode == MODE_MOESI) ? ST_O : ST_S;
                    end else if (ev == EV_WR) begin
                        d.send = 1'b1;
                        d.kind = KIND_DATA;
                        d.act  = ACT_INV;
                        d.nxt  = ST_I;
                    end
                end
                ST_S: begin
                    if (ev == EV_WR) begin
                        d.act = ACT_INV;
                        d.nxt = ST_I;
                    end
                end
                ST_E, ST_O: begin
                    if (rdlike) begin
                        d.send = 1'b1;
                        d.kind = KIND_SHARED;
                        d.act  = ACT_SHARE;
                        d.nxt  = (cur == ST_E) ? ST_S : ST_O;
                    end else if (ev == EV_WR) begin
                        d.send = 1'b1;
                        d.kind = KIND_DATA;
                        d.act  = ACT_INV;
                        d.nxt  = ST_I;
                    end
                end
                ST_IM: begin
                    if ((ev == EV_DATA) || ((mode == MODE_MI) && (ev == EV_SHARED))) begin
                        d.act = ACT_RECV;
                        d.nxt = ST_M;
                    end
                end
                ST_IS: begin
                    if (ev == EV_SHARED) begin
                        d.act = ACT_RECV;
                        d.nxt = ST_S;
                    end else if (ev == EV_DATA) begin
                        d.act = ACT_RECV;
                        d.nxt = (mode == MODE_MSI) ? ST_S : ST_E;
                    end
                end
                ST_SM: begin
                    if (ev == EV_DATA) begin
                        d.act = ACT_RECV;
                        d.nxt = ST_M;
                    end else if ((mode == MODE_MSI) && (ev == EV_NONE)) begin
                        d.nxt = ST_M;
                    end
                end
                ST_OM: begin
                    if (ev == EV_DATA) begin
                        d.act = ACT_RECV;
                        d.nxt = ST_M;
                    end
                end
                default: begin
                    // Invalid lines ignore snoops.
                end
            endcase
        end
        return d;
    endfunction

    // Line index folded onto the line count, as a constant table.
    logic [IDX_W-1:0] mod_tab [INDEX_SPAN];
    for (genvar g = 0; g < INDEX_SPAN; g++) begin : g_mod
        assign mod_tab[g] = IDX_W'(g % DEPTH);
    end

    logic [STATE_W-1:0] line_mem [DEPTH];
    logic [DEPTH-1:0]   line_vld_reg;

    logic [MODE_W-1:0]  mode_reg;
    logic [CACHE_W-1:0] cache_id_reg;
    logic [COUNT_W-1:0] sent_cnt_reg, sent_cnt_next;

    logic               opcode_reg;
    logic               is_read_reg;
    logic [EVENT_W-1:0] event_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [STATE_W-1:0] rd_state_reg;
    logic               rd_vld_reg;

    logic [STATE_W-1:0] cur_state;
    decision_t          dec;
    logic [IDX_W-1:0]   in_idx;

    assign in_idx        = mod_tab[s_line_index];
    assign cur_state     = rd_vld_reg ? rd_state_reg : ST_I;
    assign dec           = decide(mode_reg, cur_state, opcode_reg, is_read_reg, event_reg);
    assign sent_cnt_next = dec.send ? (sent_cnt_reg + COUNT_W'(1)) : sent_cnt_reg;

    // Configuration and control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_MOESI;
            cache_id_reg <= '0;
            sent_cnt_reg <= '0;
            line_vld_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PROTOCOL_MODE: mode_reg     <= cfg_data[MODE_W-1:0];
                    CFG_CACHE_ID:      cache_id_reg <= cfg_data[CACHE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.execute) begin
                sent_cnt_reg          <= sent_cnt_next;
                line_vld_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // Line state memory: read on capture, write back on execute.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_state_reg <= line_mem[in_idx];
        end
        if (cmd.execute) begin
            line_mem[idx_reg] <= dec.nxt;
        end
    end

    // Transaction capture and valid bit of the line being read.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            opcode_reg  <= s_opcode;
            is_read_reg <= s_is_read;
            event_reg   <= s_bus_event;
            idx_reg     <= in_idx;
            addr_reg    <= s_address;
            rd_vld_reg  <= line_vld_reg[in_idx];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            m_next_state     <= dec.nxt;
            m_perm_avail     <= dec.perm;
            m_snoop_action   <= dec.act;
            m_bus_send       <= dec.send;
            m_bus_kind       <= dec.send ? dec.kind : KIND_RD;
            m_bus_address    <= dec.send ? addr_reg : '0;
            m_bus_cache      <= dec.send ? cache_id_reg : '0;
            m_protocol_error <= dec.err;
            m_requests_sent  <= sent_cnt_next;
        end
    end

endmodule

### dv/tb_snoop_invalidate_coherence_controller_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the snooping invalidation coherence controller.
// It depends on sicc_pkg and snoop_invalidate_coherence_controller_core from src.
module tb_snoop_invalidate_coherence_controller_core;
    import sicc_pkg::*;

    // The opcode field has no named codes in the package, so they live here.
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_SNOOP  = 1'b1;

    localparam int LINE_TOTAL    = 256;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 64;
    localparam int PHASE_ITEMS   = 125;
    localparam int RANDOM_PHASES = 6;

    // One transaction on the input channel.
    typedef struct {
        logic                opcode;
        logic                is_read;
        logic [EVENT_W-1:0]  bus_event;
        logic [INDEX_W-1:0]  line_index;
        logic [ADDR_W-1:0]   address;
    } coh_request_t;

    // One transaction on the result channel.
    typedef struct {
        logic [STATE_W-1:0]  next_state;
        logic                perm_avail;
        logic [ACT_W-1:0]    snoop_action;
        logic                bus_send;
        logic [KIND_W-1:0]   bus_kind;
        logic [ADDR_W-1:0]   bus_address;
        logic [CACHE_W-1:0]  bus_cache;
        logic                protocol_error;
        logic [COUNT_W-1:0]  requests_sent;
    } coh_outcome_t;

    // Tracks the coherence state of every line, predicts the outcome of each
    // accepted transaction and checks the results in order against it.
    class coherence_tracker;
        logic [STATE_W-1:0] line_state [LINE_TOTAL];
        logic [COUNT_W-1:0] sent_count;
        logic [MODE_W-1:0]  mode;
        logic [CACHE_W-1:0] cache_id;
        coh_outcome_t       pending_outcomes [$];
        int                 errors;

        function new();
            foreach (line_state[i]) line_state[i] = ST_I;
            sent_count = '0;
            mode       = MODE_MOESI;
            cache_id   = '0;
            errors     = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_PROTOCOL_MODE) mode = data[MODE_W-1:0];
            else if (idx == CFG_CACHE_ID) cache_id = data[CACHE_W-1:0];
        endfunction

        function bit state_legal(logic [STATE_W-1:0] st);
            case (st)
                ST_I, ST_M, ST_IM:   return 1'b1;
                ST_S, ST_IS, ST_SM:  return mode != MODE_MI;
                ST_E:                return mode == MODE_MESI || mode == MODE_MOESI;
                ST_O, ST_OM:         return mode == MODE_MOESI;
                default:             return 1'b0;
            endcase
        endfunction

        // Applies one transaction to the line table and the request count.
        function coh_outcome_t next_line_outcome(coh_request_t r);
            coh_outcome_t       o;
            int                 line;
            logic [STATE_W-1:0] cur;
            logic [STATE_W-1:0] nxt;
            logic [KIND_W-1:0]  kind;
            logic [ACT_W-1:0]   act;
            bit                 send;
            bit                 perm;
            bit                 err;
            bit                 rdlike;

            line   = int'(r.line_index) % LINE_TOTAL;
            cur    = line_state[line];
            nxt    = cur;
            kind   = KIND_RD;
            act    = ACT_NONE;
            send   = 1'b0;
            perm   = 1'b0;
            err    = 1'b0;
            rdlike = (r.bus_event == EV_RD) || (r.bus_event == EV_SHARED);

            if (!state_legal(cur)) begin
                nxt = ST_I;
                err = 1'b1;
            end else if (r.opcode == OP_ACCESS) begin
                case (cur)
                    ST_I: begin
                        send = 1'b1;
                        if (r.is_read && mode != MODE_MI) begin
                            kind = KIND_RD;
                            nxt  = ST_IS;
                        end else begin
                            kind = KIND_WR;
                            nxt  = ST_IM;
                        end
                    end
                    ST_M: perm = 1'b1;
                    ST_S, ST_O: begin
                        if (r.is_read) perm = 1'b1;
                        else begin
                            send = 1'b1;
                            kind = KIND_WR;
                            nxt  = (cur == ST_S) ? ST_SM : ST_OM;
                        end
                    end
                    ST_E: begin
                        perm = 1'b1;
                        if (!r.is_read) nxt = ST_M;
                    end
                    default: err = 1'b1;
                endcase
            end else begin
                case (cur)
                    ST_M: begin
                        if (mode == MODE_MI) begin
                            send = 1'b1; kind = KIND_DATA; act = ACT_INV; nxt = ST_I;
                        end else if (mode == MODE_MSI) begin
                            send = 1'b1;
                            kind = KIND_DATA;
                            if (rdlike) begin
                                act = ACT_SHARE; nxt = ST_S;
                            end else if (r.bus_event == EV_WR) begin
                                act = ACT_INV; nxt = ST_I;
                            end
                        end else if (rdlike) begin
                            send = 1'b1; kind = KIND_SHARED; act = ACT_SHARE;
                            nxt  = (mode == MODE_MOESI) ? ST_O : ST_S;
                        end else if (r.bus_event == EV_WR) begin
                            send = 1'b1; kind = KIND_DATA; act = ACT_INV; nxt = ST_I;
                        end
                    end
                    ST_S: begin
                        if (r.bus_event == EV_WR) begin
                            act = ACT_INV; nxt = ST_I;
                        end
                    end
                    ST_E, ST_O: begin
                        if (rdlike) begin
                            send = 1'b1; kind = KIND_SHARED; act = ACT_SHARE;
                            if (cur == ST_E) nxt = ST_S;
                        end else if (r.bus_event == EV_WR) begin
                            send = 1'b1; kind = KIND_DATA; act = ACT_INV; nxt = ST_I;
                        end
                    end
                    ST_IM: begin
                        if (r.bus_event == EV_DATA ||
                            (mode == MODE_MI && r.bus_event == EV_SHARED)) begin
                            act = ACT_RECV; nxt = ST_M;
                        end
                    end
                    ST_IS: begin
                        if (r.bus_event == EV_SHARED) begin
                            act = ACT_RECV; nxt = ST_S;
                        end else if (r.bus_event == EV_DATA) begin
                            act = ACT_RECV;
                            nxt = (mode == MODE_MSI) ? ST_S : ST_E;
                        end
                    end
                    ST_SM, ST_OM: begin
                        if (r.bus_event == EV_DATA) begin
                            act = ACT_RECV; nxt = ST_M;
                        end else if (cur == ST_SM && mode == MODE_MSI &&
                                     r.bus_event == EV_NONE) begin
                            nxt = ST_M;
                        end
                    end
                    default: ;
                endcase
            end

            line_state[line] = nxt;
            if (send) sent_count = sent_count + 1'b1;

            o.next_state     = nxt;
            o.perm_avail     = perm;
            o.snoop_action   = act;
            o.bus_send       = send;
            o.bus_kind       = send ? kind : '0;
            o.bus_address    = send ? r.address : '0;
            o.bus_cache      = send ? cache_id : '0;
            o.protocol_error = err;
            o.requests_sent  = sent_count;
            return o;
        endfunction

        function void note_request(coh_request_t r);
            pending_outcomes.push_back(next_line_outcome(r));
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_response(coh_outcome_t got);
            coh_outcome_t want;
            if (pending_outcomes.size() == 0) begin
                $error("result transaction arrived with nothing outstanding");
                errors++;
                return;
            end
            want = pending_outcomes.pop_front();
            compare_field("next_state", 64'(want.next_state), 64'(got.next_state));
            compare_field("perm_avail", 64'(want.perm_avail), 64'(got.perm_avail));
            compare_field("snoop_action", 64'(want.snoop_action), 64'(got.snoop_action));
            compare_field("bus_send", 64'(want.bus_send), 64'(got.bus_send));
            compare_field("bus_kind", 64'(want.bus_kind), 64'(got.bus_kind));
            compare_field("bus_address", want.bus_address, got.bus_address);
            compare_field("bus_cache", 64'(want.bus_cache), 64'(got.bus_cache));
            compare_field("protocol_error", 64'(want.protocol_error),
                          64'(got.protocol_error));
            compare_field("requests_sent", 64'(want.requests_sent), 64'(got.requests_sent));
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_opcode;
    logic                  s_is_read;
    logic [EVENT_W-1:0]    s_bus_event;
    logic [INDEX_W-1:0]    s_line_index;
    logic [ADDR_W-1:0]     s_address;
    logic                  m_valid;
    logic                  m_ready;
    logic [STATE_W-1:0]    m_next_state;
    logic                  m_perm_avail;
    logic [ACT_W-1:0]      m_snoop_action;
    logic                  m_bus_send;
    logic [KIND_W-1:0]     m_bus_kind;
    logic [ADDR_W-1:0]     m_bus_address;
    logic [CACHE_W-1:0]    m_bus_cache;
    logic                  m_protocol_error;
    logic [COUNT_W-1:0]    m_requests_sent;

    coherence_tracker tracker;

    // Shared between the stimulus, the receiver and the monitor.
    bit           gaps_on;
    bit           hold_req;
    int           hold_left;
    int           quiet_cycles;
    bit           progress;
    coh_request_t seen_request;
    coh_outcome_t seen_outcome;
    logic [INDEX_W-1:0] hot_lines [8];

    snoop_invalidate_coherence_controller_core u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_is_read        (s_is_read),
        .s_bus_event      (s_bus_event),
        .s_line_index     (s_line_index),
        .s_address        (s_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_next_state     (m_next_state),
        .m_perm_avail     (m_perm_avail),
        .m_snoop_action   (m_snoop_action),
        .m_bus_send       (m_bus_send),
        .m_bus_kind       (m_bus_kind),
        .m_bus_address    (m_bus_address),
        .m_bus_cache      (m_bus_cache),
        .m_protocol_error (m_protocol_error),
        .m_requests_sent  (m_requests_sent)
    );

    // 8 ns clock period.
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Monitor. Everything is sampled at the rising edge, before the block's
    // registers update, so the values seen are the ones the handshake used.
    // Input transactions are noted first: a result never leaves in the same
    // cycle as its own transaction, so the order only matters for safety.
    // The same block keeps the watchdog, which ends the run when no channel
    // has moved a transaction for a span set by STALL_LIMIT.
    always @(posedge aclk) begin
        if (aresetn) begin
            progress = 1'b0;
            if (cfg_valid && cfg_ready) begin
                tracker.write_register(cfg_index, cfg_data);
                progress = 1'b1;
            end
            if (s_valid && s_ready) begin
                seen_request.opcode     = s_opcode;
                seen_request.is_read    = s_is_read;
                seen_request.bus_event  = s_bus_event;
                seen_request.line_index = s_line_index;
                seen_request.address    = s_address;
                tracker.note_request(seen_request);
                progress = 1'b1;
            end
            if (m_valid && m_ready) begin
                seen_outcome.next_state     = m_next_state;
                seen_outcome.perm_avail     = m_perm_avail;
                seen_outcome.snoop_action   = m_snoop_action;
                seen_outcome.bus_send       = m_bus_send;
                seen_outcome.bus_kind       = m_bus_kind;
                seen_outcome.bus_address    = m_bus_address;
                seen_outcome.bus_cache      = m_bus_cache;
                seen_outcome.protocol_error = m_protocol_error;
                seen_outcome.requests_sent  = m_requests_sent;
                tracker.check_response(seen_outcome);
                progress = 1'b1;
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Result receiver. It drives m_ready at every falling edge. When asked for
    // back-pressure it holds m_ready low for a span set by HOLD_CYCLES, counted
    // here, so the block fills up and has to stall its input. Otherwise it stalls
    // at random, 31 times in a hundred, while gaps are enabled.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready   = 1'b0;
                hold_left = hold_left - 1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_ready   = 1'b0;
            end else begin
                m_ready = !(gaps_on && $urandom_range(99) < 31);
            end
        end
    end

    // Offers one transaction. The payload changes only at a falling edge, and
    // valid stays high from one transaction to the next when no gap is drawn,
    // so it is never lowered and raised within one time step.
    task automatic offer(input coh_request_t r);
        @(negedge aclk);
        while (gaps_on && $urandom_range(99) < 31) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_opcode     = r.opcode;
        s_is_read    = r.is_read;
        s_bus_event  = r.bus_event;
        s_line_index = r.line_index;
        s_address    = r.address;
        s_valid      = 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic issue(input logic op, input logic rd, input logic [EVENT_W-1:0] ev,
                         input logic [INDEX_W-1:0] idx, input logic [ADDR_W-1:0] addr);
        coh_request_t r;
        r.opcode     = op;
        r.is_read    = rd;
        r.bus_event  = ev;
        r.line_index = idx;
        r.address    = addr;
        offer(r);
    endtask

    // Brings the block to rest: input withdrawn, every result delivered and the
    // two-stage pipeline left to empty.
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (tracker.pending_outcomes.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Mode writes carry random upper data bits, which the block must ignore.
    task automatic set_mode(input logic [MODE_W-1:0] m);
        write_register(CFG_PROTOCOL_MODE, {2'($urandom_range(3)), m});
    endtask

    // Random transaction steered by the predicted line state. Most traffic goes
    // to a handful of hot lines so that lines walk through full sequences: a
    // line waiting in a transient state usually gets the data or shared event
    // that completes it. The rest is accesses, snoops of any kind including
    // the undefined codes, and lines picked from the whole table.
    function automatic coh_request_t pick_request();
        coh_request_t       r;
        logic [STATE_W-1:0] cur;
        int                 roll;

        if ($urandom_range(99) < 75) r.line_index = hot_lines[$urandom_range(7)];
        else r.line_index = INDEX_W'($urandom_range(LINE_TOTAL - 1));
        r.is_read   = 1'($urandom_range(1));
        r.bus_event = EVENT_W'($urandom_range(7));
        case ($urandom_range(9))
            0:       r.address = '0;
            1:       r.address = '1;
            default: r.address = {$urandom, $urandom};
        endcase

        cur  = tracker.line_state[int'(r.line_index) % LINE_TOTAL];
        roll = $urandom_range(99);
        if ((cur == ST_IM || cur == ST_IS || cur == ST_SM || cur == ST_OM) && roll < 60) begin
            r.opcode    = OP_SNOOP;
            r.bus_event = ($urandom_range(2) == 0) ? EV_SHARED : EV_DATA;
        end else if (roll < 80) begin
            r.opcode = OP_ACCESS;
        end else begin
            r.opcode = OP_SNOOP;
            if ($urandom_range(3) != 0) r.bus_event = EVENT_W'($urandom_range(4));
        end
        return r;
    endfunction

    // Phase plan for the random part: the mode of each phase, so every rule
    // set is visited and each mode change strands lines in states the new
    // mode does not know.
    logic [MODE_W-1:0] phase_mode [RANDOM_PHASES] =
        '{MODE_MOESI, MODE_MESI, MODE_MSI, MODE_MI, MODE_MOESI, MODE_MESI};

    initial begin
        tracker      = new();
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_opcode     = OP_ACCESS;
        s_is_read    = 1'b0;
        s_bus_event  = EV_NONE;
        s_line_index = '0;
        s_address    = '0;
        gaps_on      = 1'b1;
        hold_req     = 1'b0;
        hold_left    = 0;
        quiet_cycles = 0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part under the reset settings, MOESI with cache id zero.
        // Line 0 walks I, IS, E, M, O, OM, M and back to I, including an
        // access that hits the transient IS state.
        issue(OP_ACCESS, 1'b1, EV_NONE, 8'd0, '1);
        issue(OP_ACCESS, 1'b0, EV_NONE, 8'd0, 64'h0123_4567_89ab_cdef);
        issue(OP_SNOOP, 1'b0, EV_DATA, 8'd0, '0);
        issue(OP_ACCESS, 1'b0, 3'd7, 8'd0, '1);
        issue(OP_SNOOP, 1'b1, EV_RD, 8'd0, 64'h8000_0000_0000_0001);
        issue(OP_ACCESS, 1'b0, EV_NONE, 8'd0, 64'hfedc_ba98_7654_3210);
        issue(OP_SNOOP, 1'b0, EV_DATA, 8'd0, '0);
        issue(OP_SNOOP, 1'b0, EV_WR, 8'd0, '1);
        // Last line: a write miss, an undefined event that must change
        // nothing, then the data that completes it.
        issue(OP_ACCESS, 1'b0, EV_NONE, 8'd255, '0);
        issue(OP_SNOOP, 1'b1, 3'd7, 8'd255, '1);
        issue(OP_SNOOP, 1'b0, EV_DATA, 8'd255, '1);
        // Line 1 ends in S, line 2 in E for the mode change below.
        issue(OP_ACCESS, 1'b1, EV_NONE, 8'd1, '1);
        issue(OP_SNOOP, 1'b0, EV_SHARED, 8'd1, '0);
        issue(OP_ACCESS, 1'b1, EV_NONE, 8'd2, '1);
        issue(OP_SNOOP, 1'b0, EV_DATA, 8'd2, '0);

        // MSI with the highest cache id. Line 2 holds E, which MSI lacks.
        // A modified line sends data on every snoop, none included, and an
        // SM line that snoops no event becomes M without any action.
        settle();
        write_register(CFG_CACHE_ID, 4'd15);
        set_mode(MODE_MSI);
        issue(OP_ACCESS, 1'b1, EV_NONE, 8'd2, '1);
        issue(OP_SNOOP, 1'b0, EV_SHARED, 8'd255, 64'h5555_aaaa_5555_aaaa);
        issue(OP_ACCESS, 1'b0, EV_NONE, 8'd255, 64'haaaa_5555_aaaa_5555);
        issue(OP_SNOOP, 1'b0, EV_NONE, 8'd255, '0);
        issue(OP_SNOOP, 1'b0, EV_NONE, 8'd255, '1);
        issue(OP_SNOOP, 1'b0, EV_WR, 8'd1, '1);

        // MI: a read miss still issues a bus write, shared counts as the
        // data for an IM line, and any snoop evicts a modified line.
        settle();
        write_register(CFG_CACHE_ID, 4'd5);
        set_mode(MODE_MI);
        issue(OP_ACCESS, 1'b1, EV_NONE, 8'd3, '1);
        issue(OP_SNOOP, 1'b0, EV_SHARED, 8'd3, '0);
        issue(OP_ACCESS, 1'b1, EV_NONE, 8'd3, '0);
        issue(OP_SNOOP, 1'b1, EV_NONE, 8'd3, '1);

        // Random part. Phase 2 runs without any gaps on either side, phase 3
        // starts with a long receiver hold-off while the sender keeps going.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            set_mode(phase_mode[p]);
            if (p == 0) write_register(CFG_CACHE_ID, 4'd0);
            else if (p == 1) write_register(CFG_CACHE_ID, 4'd15);
            else write_register(CFG_CACHE_ID, 4'($urandom_range(15)));
            hot_lines[0] = 8'd0;
            hot_lines[1] = 8'd255;
            for (int h = 2; h < 8; h++) hot_lines[h] = INDEX_W'($urandom_range(LINE_TOTAL - 1));
            gaps_on = (p != 2);
            if (p == 3) hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) offer(pick_request());
        end

        // Let the last results drain, then keep watching for anything stray to
        // show up before the verdict.
        settle();
        gaps_on = 1'b0;
        repeat (8) @(posedge aclk);
        if (tracker.pending_outcomes.size() > 0) begin
            $error("%0d results never arrived", tracker.pending_outcomes.size());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
